@@ rtl/kcl_pkg.sv @@
package kcl_pkg;

  // key codes as sampled from the keypad scanner
  localparam logic [4:0] KEY_NONE = 5'd0;
  localparam logic [4:0] KEY_D0   = 5'd1;
  localparam logic [4:0] KEY_D9   = 5'd10;
  localparam logic [4:0] KEY_STAR = 5'd11;
  localparam logic [4:0] KEY_HASH = 5'd12;
  localparam logic [4:0] KEY_A    = 5'd13;
  localparam logic [4:0] KEY_B    = 5'd14;
  localparam logic [4:0] KEY_D    = 5'd16;

  // relay commands
  localparam logic [1:0] RELAY_NONE  = 2'd0;
  localparam logic [1:0] RELAY_CLOSE = 2'd1;
  localparam logic [1:0] RELAY_OPEN  = 2'd2;

  // display message codes
  localparam logic [3:0] MSG_NONE      = 4'd0;
  localparam logic [3:0] MSG_CLEAR     = 4'd1;
  localparam logic [3:0] MSG_CLOSED    = 4'd2;
  localparam logic [3:0] MSG_OPENED    = 4'd3;
  localparam logic [3:0] MSG_WRONG     = 4'd4;
  localparam logic [3:0] MSG_CHANGED   = 4'd5;
  localparam logic [3:0] MSG_MISMATCH  = 4'd6;
  localparam logic [3:0] MSG_REPEAT    = 4'd7;
  localparam logic [3:0] MSG_ENTER_NEW = 4'd8;
  localparam logic [3:0] MSG_ONLY_OPEN = 4'd9;

  // register map, 8 bytes per register
  localparam int unsigned ADDR_W = 5;
  localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
  localparam logic [1:0] REG_MASTER_LOW  = 2'd1;
  localparam logic [1:0] REG_MASTER_HIGH = 2'd2;
  localparam logic [1:0] REG_MASTER_LEN  = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [63:0] MASTER_LOW_RST  = 64'h0000_0615_5163_1990;
  localparam logic [7:0]  MASTER_HIGH_RST = 8'h00;
  localparam logic [4:0]  MASTER_LEN_RST  = 5'd11;

  // digits held in the master pin registers
  localparam int unsigned MASTER_STORED = 18;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [63:0] master_low;
    logic [7:0]  master_high;
    logic [4:0]  master_length;
  } cfg_t;

  typedef struct packed {
    logic master_hit;
    logic user_hit;
    logic confirm_hit;
  } match_t;

  typedef struct packed {
    logic [1:0] relay_command;
    logic [3:0] message_code;
    logic [4:0] entry_length;
    logic       entry_updated;
    logic       lock_open;
    logic       change_mode;
    logic       pin_stored;
  } res_t;

endpackage

@@ rtl/kcl_match.sv @@
module kcl_match
  import kcl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 18,
  parameter int unsigned CNT_W      = $clog2(MAX_DIGITS + 1)
) (
  input  cfg_t             cfg,
  input  logic [3:0]       entry_digits   [MAX_DIGITS],
  input  logic [CNT_W-1:0] entry_count,
  input  logic [3:0]       user_digits    [MAX_DIGITS],
  input  logic [CNT_W-1:0] user_count,
  input  logic [3:0]       confirm_digits [MAX_DIGITS],
  input  logic [CNT_W-1:0] confirm_count,
  output match_t           match
);

  localparam int unsigned LW = (CNT_W > 5) ? CNT_W : 5;

  logic [3:0]            master_dig [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] master_eq;
  logic [MAX_DIGITS-1:0] user_eq;
  logic [MAX_DIGITS-1:0] confirm_eq;

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_dig
    if (i < 16) begin : g_low
      assign master_dig[i] = cfg.master_low[4*i +: 4];
    end else if (i < MASTER_STORED) begin : g_high
      assign master_dig[i] = cfg.master_high[4*(i-16) +: 4];
    end else begin : g_none
      // entered digits are 0..9, so this never matches
      assign master_dig[i] = 4'hf;
    end

    // positions past the entry count do not take part
    assign master_eq[i]  = (CNT_W'(i) >= entry_count) || (master_dig[i] == entry_digits[i]);
    assign user_eq[i]    = (CNT_W'(i) >= entry_count) || (user_digits[i] == entry_digits[i]);
    assign confirm_eq[i] = (CNT_W'(i) >= entry_count) || (confirm_digits[i] == entry_digits[i]);
  end

  assign match.master_hit  = (LW'(entry_count) == LW'(cfg.master_length)) && (&master_eq);
  assign match.user_hit    = (user_count != '0) && (user_count == entry_count) && (&user_eq);
  assign match.confirm_hit = (confirm_count == entry_count) && (&confirm_eq);

endmodule

@@ rtl/kcl_cfg.sv @@
module kcl_cfg
  import kcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:3];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.master_low    <= MASTER_LOW_RST;
      cfg_r.master_high   <= MASTER_HIGH_RST;
      cfg_r.master_length <= MASTER_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEBOUNCE:    cfg_r.debounce_ms   <= pwdata[15:0];
        REG_MASTER_LOW:  cfg_r.master_low    <= pwdata;
        REG_MASTER_HIGH: cfg_r.master_high   <= pwdata[7:0];
        REG_MASTER_LEN:  cfg_r.master_length <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:    prdata = {48'd0, cfg_r.debounce_ms};
      REG_MASTER_LOW:  prdata = cfg_r.master_low;
      REG_MASTER_HIGH: prdata = {56'd0, cfg_r.master_high};
      REG_MASTER_LEN:  prdata = {59'd0, cfg_r.master_length};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/kcl_core.sv @@
module kcl_core
  import kcl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [4:0]  key_code,
  input  logic [31:0] now_ms,
  input  cfg_t        cfg,
  output logic        emit,
  output res_t        res
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic [4:0]       prev_key_r,      prev_key_nxt;
  logic [31:0]      last_time_r,     last_time_nxt;
  logic [CNT_W-1:0] entry_cnt_r,     entry_cnt_nxt;
  logic [CNT_W-1:0] confirm_cnt_r,   confirm_cnt_nxt;
  logic [CNT_W-1:0] user_cnt_r,      user_cnt_nxt;
  logic             open_r,          open_nxt;
  logic             changing_r,      changing_nxt;

  logic [3:0]       entry_digits_r   [MAX_DIGITS];
  logic [3:0]       confirm_digits_r [MAX_DIGITS];
  logic [3:0]       user_digits_r    [MAX_DIGITS];

  logic             digit_wr;
  logic [3:0]       digit_val;
  logic             confirm_copy;
  logic             user_copy;
  logic [31:0]      elapsed;
  logic             take;
  logic [1:0]       relay;
  logic [3:0]       msg;
  logic             updated;
  logic             stored;
  match_t           match;

  kcl_match #(
    .MAX_DIGITS (MAX_DIGITS),
    .CNT_W      (CNT_W)
  ) u_match (
    .cfg            (cfg),
    .entry_digits   (entry_digits_r),
    .entry_count    (entry_cnt_r),
    .user_digits    (user_digits_r),
    .user_count     (user_cnt_r),
    .confirm_digits (confirm_digits_r),
    .confirm_count  (confirm_cnt_r),
    .match          (match)
  );

  assign elapsed   = now_ms - last_time_r;
  // a change counts only after the debounce window has fully passed
  assign take      = (key_code != prev_key_r) && (elapsed > {16'd0, cfg.debounce_ms});
  assign digit_val = 4'(key_code - KEY_D0);

  always_comb begin
    prev_key_nxt    = prev_key_r;
    last_time_nxt   = last_time_r;
    entry_cnt_nxt   = entry_cnt_r;
    confirm_cnt_nxt = confirm_cnt_r;
    user_cnt_nxt    = user_cnt_r;
    open_nxt        = open_r;
    changing_nxt    = changing_r;
    digit_wr        = 1'b0;
    confirm_copy    = 1'b0;
    user_copy       = 1'b0;
    emit            = 1'b0;
    relay           = RELAY_NONE;
    msg             = MSG_NONE;
    updated         = 1'b0;
    stored          = 1'b0;

    if (key_code != prev_key_r) begin
      prev_key_nxt = key_code;
    end
    if (take) begin
      last_time_nxt = now_ms;
      unique case (key_code) inside
        KEY_STAR: begin
          entry_cnt_nxt = '0;
          updated       = 1'b1;
          emit          = 1'b1;
        end
        KEY_HASH: begin
          if (!changing_r) begin
            if (entry_cnt_r == '0) begin
              relay    = RELAY_CLOSE;
              open_nxt = 1'b0;
              msg      = MSG_CLOSED;
            end else if (match.master_hit || match.user_hit) begin
              relay    = RELAY_OPEN;
              open_nxt = 1'b1;
              msg      = MSG_OPENED;
            end else begin
              msg = MSG_WRONG;
            end
          end else if (confirm_cnt_r != '0) begin
            if (match.confirm_hit) begin
              user_copy    = 1'b1;
              user_cnt_nxt = entry_cnt_r;
              stored       = 1'b1;
              msg          = MSG_CHANGED;
            end else begin
              msg = MSG_MISMATCH;
            end
            confirm_cnt_nxt = '0;
            changing_nxt    = 1'b0;
          end else begin
            // first pass of the new pin, wait for the repeat
            confirm_copy    = 1'b1;
            confirm_cnt_nxt = entry_cnt_r;
            msg             = MSG_REPEAT;
          end
          entry_cnt_nxt = '0;
          updated       = 1'b1;
          emit          = 1'b1;
        end
        KEY_B: begin
          emit = 1'b1;
          if (open_r) begin
            changing_nxt = 1'b1;
            msg          = MSG_ENTER_NEW;
          end else begin
            msg = MSG_ONLY_OPEN;
          end
        end
        [KEY_D0:KEY_D9]: begin
          if (entry_cnt_r < CNT_W'(MAX_DIGITS)) begin
            digit_wr      = 1'b1;
            entry_cnt_nxt = entry_cnt_r + 1'b1;
            updated       = 1'b1;
            emit          = 1'b1;
            msg           = changing_r ? MSG_NONE : MSG_CLEAR;
          end
        end
        default: ;
      endcase
    end
  end

  assign res.relay_command = relay;
  assign res.message_code  = msg;
  assign res.entry_length  = 5'(entry_cnt_nxt);
  assign res.entry_updated = updated;
  assign res.lock_open     = open_nxt;
  assign res.change_mode   = changing_nxt;
  assign res.pin_stored    = stored;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_key_r    <= KEY_NONE;
      last_time_r   <= '0;
      entry_cnt_r   <= '0;
      confirm_cnt_r <= '0;
      user_cnt_r    <= '0;
      open_r        <= 1'b0;
      changing_r    <= 1'b0;
    end else if (fire) begin
      prev_key_r    <= prev_key_nxt;
      last_time_r   <= last_time_nxt;
      entry_cnt_r   <= entry_cnt_nxt;
      confirm_cnt_r <= confirm_cnt_nxt;
      user_cnt_r    <= user_cnt_nxt;
      open_r        <= open_nxt;
      changing_r    <= changing_nxt;
    end
  end

  // digit stores carry no reset, they are read only below their counts
  always_ff @(posedge clk) begin
    if (fire && digit_wr) begin
      entry_digits_r[entry_cnt_r[IDX_W-1:0]] <= digit_val;
    end
    if (fire && confirm_copy) begin
      confirm_digits_r <= entry_digits_r;
    end
    if (fire && user_copy) begin
      user_digits_r <= entry_digits_r;
    end
  end

endmodule

@@ rtl/keypad_code_lock_top.sv @@
// channel   direction  handshake            payload
// in_*      input      in_valid / in_ready  in_key_code[4:0], in_now_ms[31:0]
// out_*     output     out_valid/out_ready  relay, message, entry length, flags
// apb       input      psel/penable/pwrite  paddr[4:0], pwdata/prdata[63:0]
//
// an accepted sample lands in the input register; once the output register
// is free or drained it is decoded against the lock state and its result,
// if any, is loaded into the output register, which drives out_valid. sustained
// rate is one sample per cycle while results are taken, set by the single
// state-update pass. rst_n is synchronous; it clears the lock state and both
// valid flags, the digit stores keep their contents. a held result stalls the
// update stage and a full input register, which refills once that stage moves.
module keypad_code_lock_top
  import kcl_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 18
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [4:0]        in_key_code,
  input  logic [31:0]       in_now_ms,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_relay_command,
  output logic [3:0]        out_message_code,
  output logic [4:0]        out_entry_length,
  output logic              out_entry_updated,
  output logic              out_lock_open,
  output logic              out_change_mode,
  output logic              out_pin_stored,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic        in_vld_r;
  logic [4:0]  key_r;
  logic [31:0] now_r;
  logic        out_vld_r, out_vld_nxt;
  res_t        res_r;
  res_t        res;
  logic        fire;
  logic        emit;
  cfg_t        cfg;

  kcl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcl_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .key_code (key_r),
    .now_ms   (now_r),
    .cfg      (cfg),
    .emit     (emit),
    .res      (res)
  );

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  // samples that cause no result simply retire here
  assign out_vld_nxt = fire ? emit : (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key_code;
      now_r <= in_now_ms;
    end
    if (fire && emit) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_relay_command = res_r.relay_command;
  assign out_message_code  = res_r.message_code;
  assign out_entry_length  = res_r.entry_length;
  assign out_entry_updated = res_r.entry_updated;
  assign out_lock_open     = res_r.lock_open;
  assign out_change_mode   = res_r.change_mode;
  assign out_pin_stored    = res_r.pin_stored;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_stored_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pin_stored) |-> (out_message_code == MSG_CHANGED))
    else $error("pin stored without changed message");

  a_open_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_relay_command == RELAY_OPEN) |-> (out_lock_open && !out_change_mode))
    else $error("relay open without open lock");

  a_hash_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_message_code == MSG_CLOSED || out_message_code == MSG_WRONG ||
                   out_message_code == MSG_CHANGED || out_message_code == MSG_REPEAT))
      |-> (out_entry_length == 5'd0 && out_entry_updated))
    else $error("hash result with entry not cleared");

endmodule
